// ===== src/serial_day_to_calendar_date_macros.svh =====
// assertion macros for the serial day to calendar date block
// used by serial_day_to_calendar_date.sv; expects clk and rst_n in scope
`ifndef SERIAL_DAY_TO_CALENDAR_DATE_MACROS_SVH
`define SERIAL_DAY_TO_CALENDAR_DATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sdc_pkg.sv =====
// shared constants, types and the month start table for the date converter
// no dependencies; imported by serial_day_to_calendar_date
`timescale 1ns / 1ps

package sdc_pkg;

  // supported span of years
  localparam int NUM_YEARS = 256;
  localparam int BASE_YEAR = 1900;

  // field widths
  localparam int SERIAL_W = 17;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DOY_W    = 9;

  // year table sizing
  localparam int IDX_W   = (NUM_YEARS > 1) ? $clog2(NUM_YEARS) : 1;
  localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int START_W = $clog2(NUM_YEARS * 366 + 1);
  localparam int CMP_W   = (START_W > SERIAL_W) ? START_W : SERIAL_W;
  localparam int ENTRY_W = START_W + 1;

  localparam logic [IDX_W:0] NUM_YEARS_V = (IDX_W + 1)'(NUM_YEARS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_YEARS - 1);

  // first year position in the 4, 100 and 400 year cycles
  localparam logic [1:0] MOD4_INIT   = 2'(BASE_YEAR % 4);
  localparam logic [6:0] MOD100_INIT = 7'(BASE_YEAR % 100);
  localparam logic [8:0] MOD400_INIT = 9'(BASE_YEAR % 400);

  // one year table entry: leap flag and first serial of the year
  typedef struct packed {
    logic               leap;
    logic [START_W-1:0] start;
  } year_entry_t;

  // zero-based first day of month k (0..11) within the year
  function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] k);
    logic [DOY_W-1:0] base;
    logic             adj;
    begin
      adj = leap && (k >= 4'd2);
      case (k)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      month_start = base + DOY_W'(adj);
    end
  endfunction

endpackage

// ===== src/sdc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/serial_day_to_calendar_date.sv =====
// Converts a day serial (days since 1 January of the first year, 1900) into the
// Gregorian year, month, day of month and zero-based day of year over 256 years.
// After reset the block fills its year-start memory, one entry per year, and
// accepts no word meanwhile. An in-range word then has its result registered
// after a binary search over the year-start memory, one memory read and one
// compare per bit of the year index (a request state and a compare state per
// bit, since the memory's read data is registered), then the month lookup in
// the done state; the next word can be accepted once the result is registered.
// A serial past the last year skips the search and gives a zero result with
// in_range low. A stalled output holds the finished word back. One word is
// in flight at a time; the result register lets the next word be accepted
// while a finished result still waits.
// Depends on sdc_pkg and sdc_ram.
`timescale 1ns / 1ps
`include "serial_day_to_calendar_date_macros.svh"

module serial_day_to_calendar_date
  import sdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SERIAL_W-1:0] in_serial_day,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [DOY_W-1:0]    out_day_in_year,
  output logic                out_in_range
);

  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_REQ  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_r, state_nxt;

  // fill pass
  logic [IDX_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [START_W-1:0] fill_start_r, fill_start_nxt;
  logic [1:0]         mod4_r, mod4_nxt;
  logic [6:0]         mod100_r, mod100_nxt;
  logic [8:0]         mod400_r, mod400_nxt;
  logic               fill_leap;

  // search
  logic [CMP_W-1:0]   serial_r, serial_nxt;
  logic               oor_r, oor_nxt;
  logic [IDX_W-1:0]   acc_r, acc_nxt;
  logic [START_W-1:0] acc_start_r, acc_start_nxt;
  logic               acc_leap_r, acc_leap_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   probe;
  logic               probe_ok;
  year_entry_t        wr_entry;
  year_entry_t        rd_entry;
  logic [ENTRY_W-1:0] rd_data;

  // month lookup
  logic [DOY_W-1:0]   rem;
  logic [3:0]         month_idx;
  logic [DOY_W-1:0]   day_full;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]  out_year_r, out_year_nxt;
  logic [MONTH_W-1:0] out_month_r, out_month_nxt;
  logic [DAY_W-1:0]   out_day_r, out_day_nxt;
  logic [DOY_W-1:0]   out_doy_r, out_doy_nxt;
  logic               out_in_range_r, out_in_range_nxt;

  logic               in_acc;
  logic               out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // leap rule from the running year position counters
  assign fill_leap = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));

  assign wr_entry.leap  = fill_leap;
  assign wr_entry.start = fill_start_r;

  // probe index for the current search bit
  assign probe    = acc_r | (IDX_W'(1) << step_r);
  assign probe_ok = ({1'b0, probe} < NUM_YEARS_V);
  assign rd_entry = year_entry_t'(rd_data);

  // year-start memory
  sdc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_YEARS)
  ) u_year_ram (
    .clk  (clk),
    .we   (state_r == ST_FILL),
    .waddr(fill_cnt_r),
    .wdata(wr_entry),
    .raddr(probe),
    .rdata(rd_data)
  );

  // days into the year and month search over the start table
  always_comb begin
    rem       = serial_r[DOY_W-1:0] - acc_start_r[DOY_W-1:0];
    month_idx = 4'd12;
    for (int k = 11; k >= 1; k--) begin
      if (month_start(acc_leap_r, 4'(k)) > rem) begin
        month_idx = 4'(k);
      end
    end
    day_full = rem - month_start(acc_leap_r, month_idx - 4'd1) + DOY_W'(1);
  end

  // control and datapath next state
  always_comb begin
    state_nxt        = state_r;
    fill_cnt_nxt     = fill_cnt_r;
    fill_start_nxt   = fill_start_r;
    mod4_nxt         = mod4_r;
    mod100_nxt       = mod100_r;
    mod400_nxt       = mod400_r;
    serial_nxt       = serial_r;
    oor_nxt          = oor_r;
    acc_nxt          = acc_r;
    acc_start_nxt    = acc_start_r;
    acc_leap_nxt     = acc_leap_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_year_nxt     = out_year_r;
    out_month_nxt    = out_month_r;
    out_day_nxt      = out_day_r;
    out_doy_nxt      = out_doy_r;
    out_in_range_nxt = out_in_range_r;
    case (state_r)
      ST_FILL: begin
        fill_start_nxt = fill_start_r + START_W'(365) + START_W'(fill_leap);
        mod4_nxt       = mod4_r + 2'd1;
        mod100_nxt     = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
        mod400_nxt     = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
        fill_cnt_nxt   = fill_cnt_r + IDX_W'(1);
        if (fill_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          serial_nxt    = CMP_W'(in_serial_day);
          oor_nxt       = CMP_W'(in_serial_day) >= CMP_W'(fill_start_r);
          acc_nxt       = '0;
          acc_start_nxt = '0;
          acc_leap_nxt  = (MOD4_INIT == 2'd0) &&
                          ((MOD100_INIT != 7'd0) || (MOD400_INIT == 9'd0));
          step_nxt      = STEP_W'(IDX_W - 1);
          state_nxt     = oor_nxt ? ST_DONE : ST_REQ;
        end
      end
      ST_REQ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (probe_ok && (CMP_W'(rd_entry.start) <= serial_r)) begin
          acc_nxt       = probe;
          acc_start_nxt = rd_entry.start;
          acc_leap_nxt  = rd_entry.leap;
        end
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt  = step_r - STEP_W'(1);
          state_nxt = ST_REQ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (oor_r) begin
            out_year_nxt     = '0;
            out_month_nxt    = '0;
            out_day_nxt      = '0;
            out_doy_nxt      = '0;
            out_in_range_nxt = 1'b0;
          end else begin
            out_year_nxt     = YEAR_W'(BASE_YEAR) + YEAR_W'(acc_r);
            out_month_nxt    = month_idx;
            out_day_nxt      = day_full[DAY_W-1:0];
            out_doy_nxt      = rem;
            out_in_range_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_cnt_r   <= '0;
      fill_start_r <= '0;
      mod4_r       <= MOD4_INIT;
      mod100_r     <= MOD100_INIT;
      mod400_r     <= MOD400_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      fill_start_r <= fill_start_nxt;
      mod4_r       <= mod4_nxt;
      mod100_r     <= mod100_nxt;
      mod400_r     <= mod400_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    serial_r       <= serial_nxt;
    oor_r          <= oor_nxt;
    acc_r          <= acc_nxt;
    acc_start_r    <= acc_start_nxt;
    acc_leap_r     <= acc_leap_nxt;
    step_r         <= step_nxt;
    out_year_r     <= out_year_nxt;
    out_month_r    <= out_month_nxt;
    out_day_r      <= out_day_nxt;
    out_doy_r      <= out_doy_nxt;
    out_in_range_r <= out_in_range_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_year        = out_year_r;
  assign out_month       = out_month_r;
  assign out_day         = out_day_r;
  assign out_day_in_year = out_doy_r;
  assign out_in_range    = out_in_range_r;

  // checks
  `SDC_ASSERT_NOW(a_oor_zero, out_valid && !out_in_range,
    (out_year == '0) && (out_month == '0) && (out_day == '0) && (out_day_in_year == '0),
    "out of range word with nonzero fields")
  `SDC_ASSERT_NOW(a_date_sane, out_valid && out_in_range,
    (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1) &&
    (out_day_in_year <= 9'd365),
    "in range word with bad month, day or day of year")
  `SDC_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
    "second word accepted while one is in flight")

endmodule
